// File: hdl/rmt_pkg.sv
package rmt_pkg;

   localparam int CAPACITY    = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = 11;
   localparam int MEDIAN_BITS = SAMPLE_BITS + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [MEDIAN_BITS-1:0] median_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_INSERT,
      ST_MED_HI,
      ST_MED_LO,
      ST_MED_CAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_prev;
      logic shift;
      logic insert;
      logic rd_lo;
      logic cap_a;
      logic cap_b;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic greater;
      logic out_busy;
   } status_type;

endpackage

// File: hdl/rmt_req_if.sv
interface rmt_req_if;
   import rmt_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// File: hdl/rmt_rsp_if.sv
interface rmt_rsp_if;
   import rmt_pkg::*;

   logic       valid;
   logic       ready;
   median_type median_doubled;
   count_type  sample_total;
   logic       overflow;

   modport source (output valid, output median_doubled, output sample_total,
                   output overflow, input ready);
   modport sink (input valid, input median_doubled, input sample_total,
                 input overflow, output ready);
endinterface

// File: hdl/rmt_ram.sv
module rmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/rmt_ctrl.sv
module rmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  rmt_pkg::status_type status,
   output logic                req_ready,
   output rmt_pkg::cmd_type    cmd
);
   import rmt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.full ? ST_MED_HI : ST_READ;
            end
         end
         ST_READ:    state_in = status.pos_zero ? ST_INSERT : ST_COMPARE;
         ST_COMPARE: state_in = status.greater ? ST_READ : ST_INSERT;
         ST_INSERT:  state_in = ST_MED_HI;
         ST_MED_HI:  state_in = ST_MED_LO;
         ST_MED_LO:  state_in = ST_MED_CAP;
         ST_MED_CAP: state_in = ST_DONE;
         ST_DONE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = accept;
         end
         ST_READ:    cmd.rd_prev = !status.pos_zero;
         ST_COMPARE: cmd.shift = status.greater;
         ST_INSERT:  cmd.insert = 1'b1;
         ST_MED_HI:  cmd.rd_lo = 1'b0;
         ST_MED_LO: begin
            cmd.rd_lo = 1'b1;
            cmd.cap_a = 1'b1;
         end
         ST_MED_CAP: cmd.cap_b = 1'b1;
         ST_DONE:    cmd.rsp_load = !status.out_busy;
         default:    cmd = '0;
      endcase
   end
endmodule

// File: hdl/rmt_datapath.sv
module rmt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rmt_pkg::sample_type req_sample,
   input  rmt_pkg::cmd_type    cmd,
   output rmt_pkg::status_type status,
   rmt_rsp_if.source           rsp_chan
);
   import rmt_pkg::*;

   sample_type sample_ff;
   count_type  count_ff;
   count_type  pos_ff;
   logic       ovf_ff;
   sample_type a_ff;
   sample_type b_ff;
   logic       rsp_valid_ff;
   median_type median_ff;
   count_type  total_ff;
   logic       rsp_ovf_ff;

   sample_type rd_data;
   addr_type   rd_addr;
   addr_type   wr_addr;
   sample_type wr_data;
   logic       wr_en;
   addr_type   half;
   median_type median_in;

   assign half    = addr_type'(count_ff >> 1);
   assign wr_addr = pos_ff[ADDR_BITS-1:0];
   assign wr_data = cmd.shift ? rd_data : sample_ff;
   assign wr_en   = cmd.shift || cmd.insert;

   always_comb begin
      if (cmd.rd_prev) begin
         rd_addr = addr_type'(pos_ff - count_type'(1));
      end else if (cmd.rd_lo && !count_ff[0]) begin
         rd_addr = half - addr_type'(1);
      end else begin
         rd_addr = half;
      end
   end

   rmt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= count_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         pos_ff    <= count_ff;
         ovf_ff    <= (count_ff == count_type'(CAPACITY));
      end else if (cmd.shift) begin
         pos_ff <= pos_ff - count_type'(1);
      end
      if (cmd.cap_a) begin
         a_ff <= rd_data;
      end
      if (cmd.cap_b) begin
         b_ff <= rd_data;
      end
   end

   always_comb begin
      if (count_ff[0]) begin
         median_in = {a_ff, 1'b0};
      end else begin
         median_in = median_type'(a_ff) + median_type'(b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         median_ff  <= median_in;
         total_ff   <= count_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign status.full     = (count_ff == count_type'(CAPACITY));
   assign status.pos_zero = (pos_ff == '0);
   assign status.greater  = (rd_data > sample_ff);
   assign status.out_busy = rsp_valid_ff && !rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.median_doubled = median_ff;
   assign rsp_chan.sample_total   = total_ff;
   assign rsp_chan.overflow       = rsp_ovf_ff;
endmodule

// File: hdl/running_median_tracker.sv
// An accepted sample walks down the store: each held sample that moves up one place takes a
// read step and a compare-and-write step on the sample memory, and a sample that lands at the
// bottom skips the last compare before it is written. A full store drops the sample. The
// median read follows, then ST_DONE loads the result once the output is free. One transaction
// at a time is taken, the next one the cycle after the result loads.
// Reset clears the count and the result valid; the sample memory needs no clearing.
module running_median_tracker (
   input logic       clock,
   input logic       reset,
   rmt_req_if.sink   req_chan,
   rmt_rsp_if.source rsp_chan
);
   import rmt_pkg::*;

   cmd_type    cmd;
   status_type status;

   rmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   rmt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_chan.sample),
      .cmd        (cmd),
      .status     (status),
      .rsp_chan   (rsp_chan)
   );

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overflow |->
         rsp_chan.sample_total == count_type'(CAPACITY))
      else $error("overflow reported while store not full");

   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.sample_total != '0)
      else $error("result with empty store");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second transaction taken while busy");
endmodule

// File: tb/sv/running_median_tracker_test.sv
`timescale 1ns / 1ps

module running_median_tracker_test;
   import rmt_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int WATCHDOG_LIMIT = 40 * CAPACITY + 2000;

   typedef struct {
      median_type median_doubled;
      count_type  sample_total;
      logic       overflow;
   } median_report_type;

   typedef struct {
      sample_type sample;
      logic       typed;
      median_type median_doubled;
      count_type  sample_total;
      logic       overflow;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmt_req_if req_chan ();
   rmt_rsp_if rsp_chan ();

   running_median_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   sample_type        held_sorted[$];
   median_report_type pending_reports[$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   logic              sink_stall_on = 1'b1;
   bit                run_done = 1'b0;

   function automatic median_report_type predict_median(sample_type sample);
      median_report_type report;
      int                pos;
      int                n;
      logic signed [MEDIAN_BITS-1:0] lo;
      logic signed [MEDIAN_BITS-1:0] hi;
      report.overflow = 1'b0;
      if (held_sorted.size() >= CAPACITY) begin
         report.overflow = 1'b1;
      end else begin
         pos = held_sorted.size();
         while (pos > 0 && held_sorted[pos-1] > sample) begin
            pos--;
         end
         held_sorted.insert(pos, sample);
      end
      n = held_sorted.size();
      lo = held_sorted[(n - 1) / 2];
      hi = held_sorted[n / 2];
      report.median_doubled = lo + hi;
      report.sample_total = count_type'(n);
      return report;
   endfunction

   task automatic send_sample(sample_type sample, logic typed, median_report_type typed_report);
      median_report_type report;
      while (sink_stall_on && $urandom_range(99) < 33) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= sample;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      report = predict_median(sample);
      if (typed && (report.median_doubled !== typed_report.median_doubled
                    || report.sample_total !== typed_report.sample_total
                    || report.overflow !== typed_report.overflow)) begin
         $display("table row disagrees with prediction for sample %0d", sample);
      end
      pending_reports = {pending_reports, typed ? typed_report : report};
   endtask

   always @(posedge clock) begin
      median_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected transaction: median %0d total %0d overflow %0b",
                        rsp_chan.median_doubled, rsp_chan.sample_total, rsp_chan.overflow);
            end
         end else begin
            want = pending_reports.pop_front();
            if (rsp_chan.median_doubled !== want.median_doubled
                || rsp_chan.sample_total !== want.sample_total
                || rsp_chan.overflow !== want.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected median %0d total %0d overflow %0b, got %0d %0d %0b",
                           want.median_doubled, want.sample_total, want.overflow,
                           rsp_chan.median_doubled, rsp_chan.sample_total,
                           rsp_chan.overflow);
               end
            end
         end
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(sink_stall_on && $urandom_range(99) < 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && !run_done) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("running_median_tracker test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic sample_type draw_sample();
      case ($urandom_range(3))
         0: return sample_type'($urandom_range(65535));
         1: return sample_type'($signed($urandom_range(20)) - 10);
         2: return $urandom_range(1) ? sample_type'(16'sh7fff) : sample_type'(16'sh8000);
         default: return sample_type'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   initial begin
      stim_row_type      directed[$];
      median_report_type typed_report;
      stim_row_type      row;
      int                idx;

      directed = '{
         '{16'sh7fff, 1'b1, 17'sh0fffe, 11'd1, 1'b0},
         '{16'sh8000, 1'b1, -17'sd1, 11'd2, 1'b0},
         '{16'sh8000, 1'b1, 17'sh10000, 11'd3, 1'b0},
         '{16'sh7fff, 1'b1, -17'sd1, 11'd4, 1'b0},
         '{16'sh7fff, 1'b1, 17'sh0fffe, 11'd5, 1'b0},
         '{16'sh0000, 1'b0, '0, '0, 1'b0},
         '{16'sh0000, 1'b0, '0, '0, 1'b0},
         '{-16'sd1, 1'b0, '0, '0, 1'b0},
         '{16'sh5555, 1'b0, '0, '0, 1'b0},
         '{16'shaaaa, 1'b0, '0, '0, 1'b0},
         '{16'sd1, 1'b0, '0, '0, 1'b0},
         '{16'sd1, 1'b0, '0, '0, 1'b0},
         '{-16'sd2, 1'b0, '0, '0, 1'b0}
      };

      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         typed_report.median_doubled = row.median_doubled;
         typed_report.sample_total = row.sample_total;
         typed_report.overflow = row.overflow;
         send_sample(row.sample, row.typed, typed_report);
      end
      req_chan.valid <= 1'b0;

      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         sink_stall_on <= !(idx >= 300 && idx < 450);
         send_sample(draw_sample(), 1'b0, typed_report);
      end
      req_chan.valid <= 1'b0;

      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      run_done = 1'b1;
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("running_median_tracker test passed");
      end else begin
         $display("running_median_tracker test failed");
      end
      $finish;
   end

endmodule
